/* hw/rtl/shape_area_and_bounding_size_assert.svh */
// Assertion macros for the shape area and bounding size block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SHAPE_AREA_AND_BOUNDING_SIZE_ASSERT_SVH
`define SHAPE_AREA_AND_BOUNDING_SIZE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SABS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sabs assertion failed");
// condition must never be true out of reset
`define SABS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sabs forbidden condition seen");
`else
`define SABS_ASSERT(lbl, prop)
`define SABS_NEVER(lbl, cond)
`endif
`endif

/* hw/rtl/sabs_pkg.sv */
// Shared types and constants for the shape area and bounding size block.
// No dependencies.
`timescale 1ns / 1ps
package sabs_pkg;

    // shape kind carried in s_tuser
    typedef enum logic [1:0] {
        KIND_TRIANGLE  = 2'd0,
        KIND_CIRCLE    = 2'd1,
        KIND_RECTANGLE = 2'd2
    } kind_t;

    // pi in Q2.60, truncated
    localparam int PI_BITS = 62;
    localparam logic [PI_BITS-1:0] PI_Q60 = 62'h3243F6A8885A308D;
    localparam int PI_FRAC = 60;

endpackage

/* hw/rtl/sabs_wmul.sv */
// Two-stage wide unsigned multiplier: four half-width partial products, then a sum.
// No dependencies.
`timescale 1ns / 1ps
module sabs_wmul #(
    parameter int WA = 34,
    parameter int WB = 34
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    localparam int HA = (WA + 1) / 2;
    localparam int HB = (WB + 1) / 2;
    localparam int WP = WA + WB;

    logic [HA-1:0]    a_lo;
    logic [WA-HA-1:0] a_hi;
    logic [HB-1:0]    b_lo;
    logic [WB-HB-1:0] b_hi;

    logic [HA+HB-1:0] ll_reg, ll_next;
    logic [HA+HB-1:0] lh_reg, lh_next;
    logic [HA+HB-1:0] hl_reg, hl_next;
    logic [HA+HB-1:0] hh_reg, hh_next;
    logic [WP-1:0]    p_reg, p_next;

    assign a_lo = a[HA-1:0];
    assign a_hi = a[WA-1:HA];
    assign b_lo = b[HB-1:0];
    assign b_hi = b[WB-1:HB];

    always_comb
    begin
        ll_next = (HA+HB)'(a_lo) * (HA+HB)'(b_lo);
        lh_next = (HA+HB)'(a_lo) * (HA+HB)'(b_hi);
        hl_next = (HA+HB)'(a_hi) * (HA+HB)'(b_lo);
        hh_next = (HA+HB)'(a_hi) * (HA+HB)'(b_hi);
        p_next  = WP'(ll_reg) + (WP'(lh_reg) << HB) + (WP'(hl_reg) << HA)
                + (WP'(hh_reg) << (HA + HB));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;
endmodule

/* hw/rtl/sabs_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit from two radicand bits.
// No dependencies; carries a side payload along unchanged.
`timescale 1ns / 1ps
module sabs_sqrt_cell #(
    parameter int NR    = 35,
    parameter int WPE   = 70,
    parameter int WPASS = 49
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WPE-1:0]   p_in,
    input  logic [NR:0]      rem_in,
    input  logic [NR-1:0]    root_in,
    input  logic [WPASS-1:0] pass_in,
    output logic [WPE-1:0]   p_out,
    output logic [NR:0]      rem_out,
    output logic [NR-1:0]    root_out,
    output logic [WPASS-1:0] pass_out
);
    logic [NR+2:0]    rem_w;
    logic [NR+2:0]    trial;
    logic [NR+2:0]    diff;
    logic             ge;

    logic [WPE-1:0]   p_reg, p_next;
    logic [NR:0]      rem_reg, rem_next;
    logic [NR-1:0]    root_reg, root_next;
    logic [WPASS-1:0] pass_reg;

    always_comb
    begin
        rem_w     = {rem_in, p_in[WPE-1:WPE-2]};
        trial     = (NR+3)'({root_in, 2'b01});
        ge        = rem_w >= trial;
        diff      = rem_w - trial;
        rem_next  = ge ? diff[NR:0] : rem_w[NR:0];
        root_next = {root_in[NR-2:0], ge};
        p_next    = {p_in[WPE-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pass_reg <= pass_in;
        end
    end

    assign p_out    = p_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign pass_out = pass_reg;
endmodule

/* hw/rtl/sabs_div_cell.sv */
// One cell of the restoring divider chain: produces one quotient bit.
// No dependencies.
`timescale 1ns / 1ps
module sabs_div_cell #(
    parameter int NR = 35,
    parameter int NQ = 49
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NQ-1:0] n_in,
    input  logic [NR-1:0] rem_in,
    input  logic [NR-1:0] d_in,
    input  logic [NQ-1:0] q_in,
    output logic [NQ-1:0] n_out,
    output logic [NR-1:0] rem_out,
    output logic [NR-1:0] d_out,
    output logic [NQ-1:0] q_out
);
    logic [NR:0]   rem_w;
    logic [NR:0]   diff;
    logic          ge;

    logic [NQ-1:0] n_reg, n_next;
    logic [NR-1:0] rem_reg, rem_next;
    logic [NR-1:0] d_reg;
    logic [NQ-1:0] q_reg, q_next;

    always_comb
    begin
        rem_w    = {rem_in, n_in[NQ-1]};
        ge       = rem_w >= {1'b0, d_in};
        diff     = rem_w - {1'b0, d_in};
        rem_next = ge ? diff[NR-1:0] : rem_w[NR-1:0];
        q_next   = {q_in[NQ-2:0], ge};
        n_next   = {n_in[NQ-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
            d_reg   <= d_in;
            q_reg   <= q_next;
        end
    end

    assign n_out   = n_reg;
    assign rem_out = rem_reg;
    assign d_out   = d_reg;
    assign q_out   = q_reg;
endmodule

/* hw/rtl/shape_area_and_bounding_size.sv */
// Shape area and bounding size, top level.
// Uses sabs_pkg, sabs_wmul, sabs_sqrt_cell, sabs_div_cell and the assertion header.
`timescale 1ns / 1ps
`include "shape_area_and_bounding_size_assert.svh"
// Takes one shape per transfer and returns one result per shape, in order. A new
// shape is accepted every cycle while s_tready is high; s_tready drops only when
// both the output register and the skid register behind it are full. A shape
// passes through the side sums and products register, the wide multipliers, the
// 2*LENGTH_BITS+3 cells of the square root chain (one root bit each) and the
// 3*LENGTH_BITS+1 cells of the divider chain for the circumcircle diameter, then
// the output register. Circles and rectangles ride the same pipeline through
// a sideband shift line so results never reorder. Lengths are unsigned fixed point
// with any fraction width; the area carries twice that fraction width.
module shape_area_and_bounding_size #(
    parameter int LENGTH_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata, from bit 0: side_a, side_b, side_c, zero fill
    input  logic [((3*LENGTH_BITS+7)/8)*8-1:0] s_tdata,
    // shape kind on s_tuser (sabs_pkg::kind_t)
    input  logic [1:0] s_tuser,
    input  logic       s_tvalid,
    output logic       s_tready,
    // m_tdata, from bit 0: area, box_width, box_height, zero fill
    output logic [((4*LENGTH_BITS+2+7)/8)*8-1:0] m_tdata,
    // m_tuser, from bit 0: degenerate, box_overflow
    output logic [1:0] m_tuser,
    output logic       m_tvalid,
    input  logic       m_tready
);
    import sabs_pkg::*;

    localparam int L   = LENGTH_BITS;
    localparam int AW  = 2*L + 2;            // area width
    localparam int NR  = 2*L + 3;            // root width
    localparam int WP  = 4*L + 5;            // radicand width
    localparam int WPE = 4*L + 6;            // radicand, even
    localparam int NQ  = 3*L + 1;            // numerator / quotient width
    localparam int TDO = ((4*L + 2 + 7) / 8) * 8;
    localparam int NTW = 4*L + 4;            // early sideband
    localparam int SBW = AW + 2*L + 3;       // sideband through the chains
    localparam int DL  = NR + NQ;
    localparam int RW  = AW + 2*L + 2;       // result vector
    localparam int CW  = 2*L + PI_BITS;

    // output register with skid, declared ahead of the stall enable
    logic          out_vld_reg, out_vld_next;
    logic          skid_vld_reg, skid_vld_next;
    logic [RW-1:0] out_reg, out_next;
    logic [RW-1:0] skid_reg, skid_next;

    logic en;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // ---- stage 1: side sums, triangle check, narrow products ----
    logic [L-1:0]     a_in, b_in, c_in;
    logic [L:0]       sum_bc, sum_ac, sum_ab;
    logic [L+1:0]     s1;
    logic [L:0]       s2, s3, s4;
    logic             tri_ok;
    logic [NTW-1:0]   nt1_next;
    logic [2*L+2:0]   x12_next;
    logic [2*L+1:0]   x34_next;
    logic [2*L-1:0]   ab_next, aa_next;
    logic [L:0]       side2;
    logic             is_tri, is_circ, is_rect;
    logic [L-1:0]     w1, h1;
    logic             ovf1;

    logic             v1_reg, v2_reg, v3_reg;
    logic [NTW-1:0]   nt1_reg, nt2_reg, nt3_reg;
    logic [2*L+2:0]   x12_reg;
    logic [2*L+1:0]   x34_reg;
    logic [2*L-1:0]   ab_reg, aa_reg;
    logic [L-1:0]     c_reg;

    always_comb
    begin
        a_in    = s_tdata[L-1:0];
        b_in    = s_tdata[2*L-1:L];
        c_in    = s_tdata[3*L-1:2*L];
        sum_bc  = (L+1)'(b_in) + (L+1)'(c_in);
        sum_ac  = (L+1)'(a_in) + (L+1)'(c_in);
        sum_ab  = (L+1)'(a_in) + (L+1)'(b_in);
        tri_ok  = (sum_bc > (L+1)'(a_in)) && (sum_ac > (L+1)'(b_in))
               && (sum_ab > (L+1)'(c_in));
        s1      = (L+2)'(sum_ab) + (L+2)'(c_in);
        s2      = sum_bc - (L+1)'(a_in);
        s3      = sum_ac - (L+1)'(b_in);
        s4      = sum_ab - (L+1)'(c_in);
        x12_next = (2*L+3)'(s1) * (2*L+3)'(s2);
        x34_next = (2*L+2)'(s3) * (2*L+2)'(s4);
        ab_next  = (2*L)'(a_in) * (2*L)'(b_in);
        aa_next  = (2*L)'(a_in) * (2*L)'(a_in);
        side2    = {a_in, 1'b0};
        is_tri   = 1'b0;
        is_circ  = 1'b0;
        is_rect  = 1'b0;
        w1       = '0;
        h1       = '0;
        ovf1     = 1'b0;
        case (kind_t'(s_tuser))
            KIND_TRIANGLE:
            begin
                is_tri = 1'b1;
            end
            KIND_CIRCLE:
            begin
                is_circ = 1'b1;
                ovf1    = side2[L];
                w1      = side2[L] ? '1 : side2[L-1:0];
                h1      = w1;
            end
            KIND_RECTANGLE:
            begin
                is_rect = 1'b1;
                w1      = a_in;
                h1      = b_in;
            end
            default:
            begin
                w1 = '0;
            end
        endcase
        // {is_tri, ok, is_circ, rect area, w, h, ovf}; unused kind carries a zero area
        nt1_next = {is_tri, tri_ok, is_circ, (is_rect ? ab_next : {(2*L){1'b0}}),
                    w1, h1, ovf1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nt1_reg <= nt1_next;
            nt2_reg <= nt1_reg;
            nt3_reg <= nt2_reg;
            x12_reg <= x12_next;
            x34_reg <= x34_next;
            ab_reg  <= ab_next;
            aa_reg  <= aa_next;
            c_reg   <= c_in;
        end
    end

    // ---- stages 2-3: wide products ----
    logic [WP-1:0] p_prod;   // 16*K^2
    logic [NQ-1:0] n_prod;   // 2abc
    logic [CW-1:0] c_prod;   // r^2 * pi

    sabs_wmul #(.WA(2*L+3), .WB(2*L+2)) u_mul_p (
        .clk(clk), .en(en), .a(x12_reg), .b(x34_reg), .p(p_prod)
    );
    sabs_wmul #(.WA(2*L+1), .WB(L)) u_mul_n (
        .clk(clk), .en(en), .a({ab_reg, 1'b0}), .b(c_reg), .p(n_prod)
    );
    sabs_wmul #(.WA(2*L), .WB(PI_BITS)) u_mul_c (
        .clk(clk), .en(en), .a(aa_reg), .b(PI_Q60), .p(c_prod)
    );

    // non-triangle results are final here; they ride the sideband line
    logic [AW-1:0]  area_nt;
    logic [SBW-1:0] sb_in;

    always_comb
    begin
        if (nt3_reg[NTW-3])
            area_nt = c_prod[PI_FRAC+AW-1:PI_FRAC];
        else
            area_nt = AW'(nt3_reg[4*L:2*L+1]);
        // {is_tri, ok, area, w, h, ovf}
        sb_in = {nt3_reg[NTW-1], nt3_reg[NTW-2], area_nt, nt3_reg[2*L:0]};
    end

    // ---- square root chain ----
    logic [WPE-1:0] sq_p    [NR+1];
    logic [NR:0]    sq_rem  [NR+1];
    logic [NR-1:0]  sq_root [NR+1];
    logic [NQ-1:0]  sq_pass [NR+1];

    assign sq_p[0]    = WPE'(p_prod);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pass[0] = n_prod;

    for (genvar k = 0; k < NR; k++)
    begin : g_sqrt
        sabs_sqrt_cell #(.NR(NR), .WPE(WPE), .WPASS(NQ)) u_cell (
            .clk(clk), .en(en),
            .p_in(sq_p[k]), .rem_in(sq_rem[k]), .root_in(sq_root[k]),
            .pass_in(sq_pass[k]),
            .p_out(sq_p[k+1]), .rem_out(sq_rem[k+1]), .root_out(sq_root[k+1]),
            .pass_out(sq_pass[k+1])
        );
    end

    // ---- divider chain: 2abc / R ----
    logic [NQ-1:0] dv_n   [NQ+1];
    logic [NR-1:0] dv_rem [NQ+1];
    logic [NR-1:0] dv_d   [NQ+1];
    logic [NQ-1:0] dv_q   [NQ+1];

    assign dv_n[0]   = sq_pass[NR];
    assign dv_rem[0] = '0;
    assign dv_d[0]   = sq_root[NR];
    assign dv_q[0]   = '0;

    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        sabs_div_cell #(.NR(NR), .NQ(NQ)) u_cell (
            .clk(clk), .en(en),
            .n_in(dv_n[k]), .rem_in(dv_rem[k]), .d_in(dv_d[k]), .q_in(dv_q[k]),
            .n_out(dv_n[k+1]), .rem_out(dv_rem[k+1]), .d_out(dv_d[k+1]),
            .q_out(dv_q[k+1])
        );
    end

    // ---- sideband and valid line alongside the chains ----
    logic [SBW-1:0] sb_reg [DL];
    logic [DL-1:0]  vl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vl_reg <= '0;
        else if (en)
            vl_reg <= {vl_reg[DL-2:0], v3_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int k = 1; k < DL; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // ---- final result ----
    logic [SBW-1:0] sb_last;
    logic           pipe_vld;
    logic [NQ-1:0]  q_last;
    logic           q_sat;
    logic [L-1:0]   tri_side;
    logic [RW-1:0]  res;

    always_comb
    begin
        sb_last  = sb_reg[DL-1];
        pipe_vld = vl_reg[DL-1];
        q_last   = dv_q[NQ];
        q_sat    = |q_last[NQ-1:L];
        tri_side = q_sat ? '1 : q_last[L-1:0];
        if (sb_last[SBW-1])
        begin
            if (sb_last[SBW-2])
                res = {q_sat, 1'b0, tri_side, tri_side, AW'(dv_d[NQ][NR-1:2])};
            else
                res = {1'b0, 1'b1, {(2*L){1'b0}}, {AW{1'b0}}};
        end
        else
        begin
            // {ovf, bad, h, w, area}
            res = {sb_last[0], 1'b0, sb_last[L:1], sb_last[2*L:L+1],
                   sb_last[SBW-3:2*L+1]};
        end
    end

    // ---- output register with skid ----
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_next      = out_reg;
        skid_next     = skid_reg;
        if (!out_vld_reg || m_tready)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else if (pipe_vld)
            begin
                out_next     = res;
                out_vld_next = 1'b1;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        else if (en && pipe_vld)
        begin
            skid_next     = res;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDO'(out_reg[AW+2*L-1:0]);
    assign m_tuser  = out_reg[RW-1:AW+2*L];

    // ---- assertions ----
    `SABS_ASSERT(a_skid_behind_out, skid_vld_reg |-> out_vld_reg)
    `SABS_ASSERT(a_skid_fills_on_stall,
        (out_vld_reg && !m_tready && !skid_vld_reg && pipe_vld) |=> skid_vld_reg)
    `SABS_ASSERT(a_degenerate_zero,
        (out_vld_reg && out_reg[AW+2*L]) |-> (out_reg[AW+2*L-1:0] == '0 && !out_reg[RW-1]))
    `SABS_NEVER(a_overflow_at_max,
        out_vld_reg && out_reg[RW-1] && (out_reg[AW+L-1:AW] != {L{1'b1}}))
endmodule
